// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of i_clk, off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge of i_clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lcar_pkg.sv -----
// Types and constants for the load-cell converter reader
package lcar_pkg;

    localparam int DATA_BITS = 24;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 8;
    localparam int HP_W      = 10;
    localparam int GAIN_W    = 2;
    localparam int NET_W     = DATA_BITS + 1;
    localparam int BIT_W     = 5;
    localparam int DIV_STEPS = SUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int ACT_W     = 3;
    localparam int IDX_W     = 2;
    localparam int CFG_W     = HP_W;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 56;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(1);
    localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(10);
    localparam logic [HP_W-1:0]   HALF_RESET  = HP_W'(50);

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_READ   = 3'd1,
        ACT_TARE   = 3'd2,
        ACT_PDOWN  = 3'd3,
        ACT_PUP    = 3'd4,
        ACT_SETOFS = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } t_phase;

    typedef enum logic {
        ST_RUN = 1'b0,
        ST_DIV = 1'b1
    } t_ctl;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN  = 2'd0,
        REG_COUNT = 2'd1,
        REG_HALF  = 2'd2
    } t_reg_idx;

endpackage

// ----- design/load_cell_adc_reader_unit.sv -----
// Load-cell converter reader: pin sequencer with a shared serial divider for averaging
// Each input transfer is one pin sequencer tick; a tick that does not finish a request
// yields its result transfer the next cycle, one transfer per cycle while results are taken.
// A finishing tick runs the restoring divider, one quotient bit per cycle, and the result
// is registered when it ends; no input is taken meanwhile.
// Synchronous active-low reset: idle, powered up, offset zero, registers at defaults.
module load_cell_adc_reader_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lcar_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [lcar_pkg::CFG_W-1:0]  i_cfg_data,
    // input ticks
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lcar_pkg::IN_W-1:0]   s_axis_tdata,  // dout_level, offset_value, zero pad
    input  logic [lcar_pkg::ACT_W-1:0]  s_axis_tuser,  // action
    // results
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [lcar_pkg::OUT_W-1:0]  m_axis_tdata,  // sck_level, busy_res, result_valid,
                                                       // net_value, average_value, zero pad
    output logic                        m_axis_tuser   // result_kind
);
    import lcar_pkg::*;

    `include "assert_macros.svh"

    // configuration
    logic [GAIN_W-1:0] r_gain;
    logic [CNT_W-1:0]  r_count;
    logic [HP_W-1:0]   r_half;

    // sequencer state
    t_phase                r_phase, n_phase;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [HP_W-1:0]       r_hp_cnt, n_hp_cnt;
    logic [DATA_BITS-1:0]  r_shift, n_shift;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [CNT_W-1:0]      r_conv, n_conv;
    logic [DATA_BITS-1:0]  r_offset, n_offset;
    logic                  r_is_tare, n_is_tare;
    logic                  r_pd, n_pd;
    logic                  w_finish;

    // divider
    t_ctl                  r_ctl, n_ctl;
    logic [CNT_W-1:0]      r_rem;
    logic [SUM_W-1:0]      r_quo;
    logic                  r_neg;
    logic [DCNT_W-1:0]     r_dcnt;

    // output register
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic                  r_out_kind;

    logic                  w_in_acc;
    t_action               w_act;
    logic                  w_dout;
    logic [DATA_BITS-1:0]  w_ofs_in;
    logic [HP_W-1:0]       w_hp;
    logic [GAIN_W-1:0]     w_gp;
    logic [CNT_W-1:0]      w_sc;
    logic [SUM_W-1:0]      w_sum_new;
    logic [SUM_W-1:0]      w_sum_abs;
    logic [CNT_W-1:0]      w_conv_new;

    logic [CNT_W:0]        w_rem_sh;
    logic                  w_ge;
    logic [CNT_W:0]        w_rem_nx;
    logic [SUM_W-1:0]      w_quo_nx;
    logic                  w_div_last;
    logic [DATA_BITS-1:0]  w_mag;
    logic [DATA_BITS-1:0]  w_avg;
    logic [NET_W-1:0]      w_net;
    logic [OUT_W-1:0]      w_tick_data;
    logic [OUT_W-1:0]      w_fin_data;

    assign w_act    = t_action'(s_axis_tuser);
    assign w_dout   = s_axis_tdata[0];
    assign w_ofs_in = s_axis_tdata[DATA_BITS:1];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // zero registers act as one
    assign w_hp = (r_half  == '0) ? HP_W'(1)   : r_half;
    assign w_gp = (r_gain  == '0) ? GAIN_W'(1) : r_gain;
    assign w_sc = (r_count == '0) ? CNT_W'(1)  : r_count;

    assign w_sum_new  = r_sum + {{(SUM_W-DATA_BITS){r_shift[DATA_BITS-1]}}, r_shift};
    assign w_sum_abs  = w_sum_new[SUM_W-1] ? (~w_sum_new + SUM_W'(1)) : w_sum_new;
    assign w_conv_new = r_conv + CNT_W'(1);

    // sequencer next state
    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_hp_cnt  = r_hp_cnt;
        n_shift   = r_shift;
        n_sum     = r_sum;
        n_conv    = r_conv;
        n_offset  = r_offset;
        n_is_tare = r_is_tare;
        n_pd      = r_pd;
        w_finish  = 1'b0;

        if (w_act == ACT_SETOFS) begin
            n_offset = w_ofs_in;
        end

        if (w_act == ACT_PDOWN) begin
            n_pd     = 1'b1;
            n_phase  = PH_IDLE;
            n_bit    = '0;
            n_hp_cnt = '0;
            n_shift  = '0;
            n_sum    = '0;
            n_conv   = '0;
        end else if (w_act == ACT_PUP) begin
            n_pd = 1'b0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if ((w_act == ACT_READ || w_act == ACT_TARE) && !r_pd) begin
                        n_phase   = PH_WAIT;
                        n_is_tare = (w_act == ACT_TARE);
                        n_bit     = '0;
                        n_hp_cnt  = '0;
                        n_shift   = '0;
                        n_sum     = '0;
                        n_conv    = '0;
                    end
                end
                PH_WAIT: begin
                    if (!w_dout) begin
                        n_bit    = '0;
                        n_hp_cnt = '0;
                        n_shift  = '0;
                        n_phase  = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    if (({1'b0, r_hp_cnt} + (HP_W+1)'(1)) < {1'b0, w_hp}) begin
                        n_hp_cnt = r_hp_cnt + HP_W'(1);
                    end else begin
                        n_hp_cnt = '0;
                        // sample on the last tick of the high half
                        if ({1'b0, r_bit} < (BIT_W+1)'(DATA_BITS)) begin
                            n_shift = {r_shift[DATA_BITS-2:0], w_dout};
                        end
                        n_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (({1'b0, r_hp_cnt} + (HP_W+1)'(1)) < {1'b0, w_hp}) begin
                        n_hp_cnt = r_hp_cnt + HP_W'(1);
                    end else begin
                        n_hp_cnt = '0;
                        n_bit    = r_bit + BIT_W'(1);
                        if ({1'b0, n_bit} <
                            ((BIT_W+1)'(DATA_BITS) + {{(BIT_W+1-GAIN_W){1'b0}}, w_gp})) begin
                            n_phase = PH_HIGH;
                        end else if (w_conv_new >= w_sc) begin
                            w_finish = 1'b1;
                            n_phase  = PH_IDLE;
                            n_sum    = '0;
                            n_conv   = '0;
                            n_bit    = '0;
                            n_shift  = '0;
                        end else begin
                            n_phase = PH_WAIT;
                            n_sum   = w_sum_new;
                            n_conv  = w_conv_new;
                            n_bit   = '0;
                            n_shift = '0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // control next state
    always_comb begin
        n_ctl = r_ctl;
        unique case (r_ctl)
            ST_RUN: begin
                if (w_in_acc && w_finish) begin
                    n_ctl = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_last) begin
                    n_ctl = ST_RUN;
                end
            end
            default: n_ctl = ST_RUN;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        unique case (r_ctl)
            ST_RUN:  s_axis_tready = !r_out_valid || m_axis_tready;
            ST_DIV:  s_axis_tready = 1'b0;
            default: s_axis_tready = 1'b0;
        endcase
    end

    // one restoring divide step: shift in the next dividend bit, subtract if it fits
    assign w_rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign w_ge       = w_rem_sh >= {1'b0, w_sc};
    assign w_rem_nx   = w_ge ? (w_rem_sh - {1'b0, w_sc}) : w_rem_sh;
    assign w_quo_nx   = {r_quo[SUM_W-2:0], w_ge};
    assign w_div_last = (r_ctl == ST_DIV) && (r_dcnt == DCNT_W'(DIV_STEPS - 1));

    // quotient magnitude is at most 2^23, so the low bits hold it
    assign w_mag = w_quo_nx[DATA_BITS-1:0];
    assign w_avg = r_neg ? (~w_mag + DATA_BITS'(1)) : w_mag;
    assign w_net = r_is_tare ? '0
                 : ({w_avg[DATA_BITS-1], w_avg} - {r_offset[DATA_BITS-1], r_offset});

    assign w_tick_data = {{(OUT_W-NET_W-DATA_BITS-3){1'b0}}, {DATA_BITS{1'b0}},
                          {NET_W{1'b0}}, 1'b0, (n_phase != PH_IDLE),
                          (n_pd || n_phase == PH_HIGH)};
    assign w_fin_data  = {{(OUT_W-NET_W-DATA_BITS-3){1'b0}}, w_avg, w_net,
                          1'b1, 1'b0, 1'b0};

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_count <= COUNT_RESET;
            r_half  <= HALF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                REG_HALF:  r_half  <= i_cfg_data[HP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= ST_RUN;
            r_phase   <= PH_IDLE;
            r_bit     <= '0;
            r_hp_cnt  <= '0;
            r_shift   <= '0;
            r_sum     <= '0;
            r_conv    <= '0;
            r_offset  <= '0;
            r_is_tare <= 1'b0;
            r_pd      <= 1'b0;
            r_dcnt    <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (w_in_acc) begin
                r_phase   <= n_phase;
                r_bit     <= n_bit;
                r_hp_cnt  <= n_hp_cnt;
                r_shift   <= n_shift;
                r_sum     <= n_sum;
                r_conv    <= n_conv;
                r_offset  <= n_offset;
                r_is_tare <= n_is_tare;
                r_pd      <= n_pd;
                r_dcnt    <= '0;
            end else if (r_ctl == ST_DIV) begin
                r_dcnt <= r_dcnt + DCNT_W'(1);
                // a finished tare stores its average as the new offset
                if (w_div_last && r_is_tare) begin
                    r_offset <= w_avg;
                end
            end
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_finish) begin
            r_rem <= '0;
            r_quo <= w_sum_abs;
            r_neg <= w_sum_new[SUM_W-1];
        end else if (r_ctl == ST_DIV) begin
            r_rem <= w_rem_nx[CNT_W-1:0];
            r_quo <= w_quo_nx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_in_acc && !w_finish) || w_div_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_finish) begin
            r_out_data <= w_tick_data;
            r_out_kind <= 1'b0;
        end else if (w_div_last) begin
            r_out_data <= w_fin_data;
            r_out_kind <= r_is_tare;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    `ASSERT_SAME(a_no_take_in_div, r_ctl == ST_DIV, !s_axis_tready, "input taken while dividing")
    `ASSERT_NEXT(a_div_gives_result, w_div_last, r_out_valid && r_ctl == ST_RUN, "result lost")
    `ASSERT_SAME(a_pd_idle, r_pd, r_phase == PH_IDLE, "sequence running while powered down")
    `ASSERT_SAME(a_div_out_free, r_ctl == ST_DIV, !r_out_valid, "output busy while dividing")

endmodule
